FILE: hdl/sob_pkg.sv
// Shared types and constants for the second-order absorbing boundary block.
`default_nettype none

package sob_pkg;

    // Field and coefficient formats
    localparam int FIELD_W  = 32;   // signed Q16.16
    localparam int COEF_W   = 20;   // signed Q4.16
    localparam int FRAC_W   = 16;
    localparam int POS_W    = 8;
    localparam int KIND_W   = 2;
    localparam int HIST_N   = 6;    // three positions times two past steps
    localparam int ACC_W    = 56;   // exact sum of all product terms
    localparam int TDATA_IN_W  = 72;
    localparam int TDATA_OUT_W = 32;

    // Grid defaults
    localparam int COLS_DEF = 256;
    localparam int ROWS_DEF = 256;

    // Coefficient reset values
    localparam logic signed [COEF_W-1:0] COEF_ZERO_RST = -20'sd1930;
    localparam logic signed [COEF_W-1:0] COEF_ONE_RST  = 20'sd22489;
    localparam logic signed [COEF_W-1:0] COEF_TWO_RST  = 20'sd134930;

    // Register indexes
    localparam int REG_IDX_W = 2;
    localparam logic [REG_IDX_W-1:0] REG_COEF_ZERO = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_COEF_ONE  = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_COEF_TWO  = 2'd2;

    // Saturation limits
    localparam logic [FIELD_W-1:0] FIELD_MAX = 32'h7fff_ffff;
    localparam logic [FIELD_W-1:0] FIELD_MIN = 32'h8000_0000;

    typedef enum logic [KIND_W-1:0] {
        SIDE_LEFT   = 2'd0,
        SIDE_RIGHT  = 2'd1,
        SIDE_BOTTOM = 2'd2,
        SIDE_TOP    = 2'd3
    } side_t;

    // One node's history: [0..2] latest step (boundary, near, far),
    // [3..5] the step before.
    typedef logic [HIST_N-1:0][FIELD_W-1:0] hist_row_t;

endpackage

`default_nettype wire

FILE: hdl/sob_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none

module sob_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: hdl/second_order_absorbing_boundary.sv
// Top level: second-order absorbing boundary update with per-node history RAM.
// Pipeline: an accepted word passes s1, s2, s3 and the result register before m_axis.
// Throughput: one word per cycle unless m_axis stalls; a word for the same node as one of
//   the three words still in the pipe waits until that word has written its history.
// Reset: coefficients return to their defaults; the history RAM is swept to zero, one row
//   a cycle, 2*min(ROWS-1,256)+2*min(COLS-1,256) rows (1020 by default), tready low.
`default_nettype none

module second_order_absorbing_boundary #(
    parameter int COLS = sob_pkg::COLS_DEF,
    parameter int ROWS = sob_pkg::ROWS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,

    // configuration write port
    input  wire logic                             cfg_we,
    input  wire logic [sob_pkg::REG_IDX_W-1:0]    cfg_addr,
    input  wire logic [sob_pkg::COEF_W-1:0]       cfg_wdata,

    // input words
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // [7:0] position, [39:8] near_value, [71:40] far_value
    input  wire logic [sob_pkg::TDATA_IN_W-1:0]   s_axis_tdata,
    // [1:0] kind
    input  wire logic [sob_pkg::KIND_W-1:0]       s_axis_tuser,

    // result words
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // [31:0] boundary_value
    output logic      [sob_pkg::TDATA_OUT_W-1:0]  m_axis_tdata
);

    import sob_pkg::*;

    // Nodes per side; position is only 8 bits, so a side never holds more than 256 rows.
    localparam int SIDE_V = ROWS - 1;
    localparam int SIDE_H = COLS - 1;
    localparam int ROWS_V = (SIDE_V < 256) ? SIDE_V : 256;
    localparam int ROWS_H = (SIDE_H < 256) ? SIDE_H : 256;
    localparam int DEPTH  = 2 * ROWS_V + 2 * ROWS_H;
    localparam int AW     = $clog2(DEPTH);
    localparam int ROW_W  = $bits(hist_row_t);

    // Row base of each side in the shared RAM
    localparam logic [AW-1:0] BASE_LEFT   = AW'(0);
    localparam logic [AW-1:0] BASE_RIGHT  = AW'(ROWS_V);
    localparam logic [AW-1:0] BASE_BOTTOM = AW'(2 * ROWS_V);
    localparam logic [AW-1:0] BASE_TOP    = AW'(2 * ROWS_V + ROWS_H);

    // ------------------------------------------------------------------
    // Coefficient registers
    // ------------------------------------------------------------------
    logic signed [COEF_W-1:0] coef_zero_reg;
    logic signed [COEF_W-1:0] coef_one_reg;
    logic signed [COEF_W-1:0] coef_two_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_zero_reg <= COEF_ZERO_RST;
            coef_one_reg  <= COEF_ONE_RST;
            coef_two_reg  <= COEF_TWO_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_COEF_ZERO: coef_zero_reg <= cfg_wdata;
                REG_COEF_ONE:  coef_one_reg  <= cfg_wdata;
                REG_COEF_TWO:  coef_two_reg  <= cfg_wdata;
                default:       ; // unmapped index, ignored
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input decode: side, range check, RAM row
    // ------------------------------------------------------------------
    side_t                 in_side;
    logic [POS_W-1:0]      in_pos;
    logic [FIELD_W-1:0]    in_near;
    logic [FIELD_W-1:0]    in_far;
    logic                  in_inr;     // node exists on that side
    logic [AW-1:0]         in_base;
    logic [AW-1:0]         in_addr;

    assign in_side = side_t'(s_axis_tuser);
    assign in_pos  = s_axis_tdata[POS_W-1:0];
    assign in_near = s_axis_tdata[POS_W +: FIELD_W];
    assign in_far  = s_axis_tdata[POS_W+FIELD_W +: FIELD_W];

    always_comb
    begin
        unique case (in_side)
            SIDE_LEFT:
            begin
                in_base = BASE_LEFT;
                in_inr  = 32'(in_pos) < 32'(SIDE_V);
            end
            SIDE_RIGHT:
            begin
                in_base = BASE_RIGHT;
                in_inr  = 32'(in_pos) < 32'(SIDE_V);
            end
            SIDE_BOTTOM:
            begin
                in_base = BASE_BOTTOM;
                in_inr  = 32'(in_pos) < 32'(SIDE_H);
            end
            SIDE_TOP:
            begin
                in_base = BASE_TOP;
                in_inr  = 32'(in_pos) < 32'(SIDE_H);
            end
            default:
            begin
                in_base = BASE_LEFT;
                in_inr  = 1'b0;
            end
        endcase
    end

    // out-of-range positions may alias here; they are read but ignored, never written
    assign in_addr = in_base + AW'(in_pos);

    // ------------------------------------------------------------------
    // Pipeline control
    // s1: RAM data back, form sums   s2: multiply   s3: sum, round, saturate,
    // write history   out: result register
    // ------------------------------------------------------------------
    logic            s1_valid_reg, s2_valid_reg, s3_valid_reg, out_valid_reg;
    logic            s1_valid_next, s2_valid_next, s3_valid_next, out_valid_next;
    logic            s1_inr_reg, s2_inr_reg, s3_inr_reg;
    logic [AW-1:0]   s1_addr_reg, s2_addr_reg, s3_addr_reg;
    logic            en_out, en3, en2, en1;
    logic            hazard;
    logic            accept;
    logic            clr_busy_reg, clr_busy_next;
    logic [AW-1:0]   clr_addr_reg, clr_addr_next;

    assign en_out = !out_valid_reg || m_axis_tready;
    assign en3    = en_out || !s3_valid_reg;
    assign en2    = en3 || !s2_valid_reg;
    assign en1    = en2 || !s1_valid_reg;

    // Interlock: a node still in flight has not written its new history yet.
    assign hazard = in_inr &&
                    ((s1_valid_reg && s1_inr_reg && (s1_addr_reg == in_addr)) ||
                     (s2_valid_reg && s2_inr_reg && (s2_addr_reg == in_addr)) ||
                     (s3_valid_reg && s3_inr_reg && (s3_addr_reg == in_addr)));

    assign s_axis_tready = en1 && !hazard && !clr_busy_reg;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        s1_valid_next  = en1    ? accept       : s1_valid_reg;
        s2_valid_next  = en2    ? s1_valid_reg : s2_valid_reg;
        s3_valid_next  = en3    ? s2_valid_reg : s3_valid_reg;
        out_valid_next = en_out ? s3_valid_reg : out_valid_reg;

        clr_busy_next = clr_busy_reg;
        clr_addr_next = clr_addr_reg;
        if (clr_busy_reg)
        begin
            clr_addr_next = clr_addr_reg + AW'(1);
            clr_busy_next = (clr_addr_reg != AW'(DEPTH - 1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            clr_busy_reg  <= 1'b1;
            clr_addr_reg  <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            s3_valid_reg  <= s3_valid_next;
            out_valid_reg <= out_valid_next;
            clr_busy_reg  <= clr_busy_next;
            clr_addr_reg  <= clr_addr_next;
        end
    end

    // ------------------------------------------------------------------
    // History RAM
    // ------------------------------------------------------------------
    hist_row_t       rd_row;
    hist_row_t       new_row;
    logic            wr_item;
    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    hist_row_t       ram_wdata;

    assign wr_item   = s3_valid_reg && s3_inr_reg && en_out;
    assign ram_we    = clr_busy_reg || wr_item;
    assign ram_waddr = clr_busy_reg ? clr_addr_reg : s3_addr_reg;
    assign ram_wdata = clr_busy_reg ? hist_row_t'('0) : new_row;

    sob_ram #(
        .WIDTH (ROW_W),
        .DEPTH (DEPTH)
    ) u_hist_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (in_addr),
        .rdata (rd_row)
    );

    // ------------------------------------------------------------------
    // Stage 1: history select and pre-adds
    // ------------------------------------------------------------------
    logic [FIELD_W-1:0]        s1_near_reg, s1_far_reg;
    hist_row_t                 s1_hist;
    logic signed [FIELD_W:0]   s1_a;     // in2 + h01
    logic signed [FIELD_W+1:0] s1_b;     // h00 + h20 - in1 - h11

    // a node beyond the side sees an all-zero history
    assign s1_hist = s1_inr_reg ? rd_row : hist_row_t'('0);

    assign s1_a = {s1_far_reg[FIELD_W-1], s1_far_reg}
                + {s1_hist[3][FIELD_W-1], s1_hist[3]};
    assign s1_b = {{2{s1_hist[0][FIELD_W-1]}}, s1_hist[0]}
                + {{2{s1_hist[2][FIELD_W-1]}}, s1_hist[2]}
                - {{2{s1_near_reg[FIELD_W-1]}}, s1_near_reg}
                - {{2{s1_hist[4][FIELD_W-1]}}, s1_hist[4]};

    // ------------------------------------------------------------------
    // Stage 2 / 3 payload
    // ------------------------------------------------------------------
    logic [FIELD_W-1:0]                s2_near_reg, s2_far_reg, s2_h0_reg, s2_h2_reg;
    logic [FIELD_W-1:0]                s2_h5_reg;
    logic signed [FIELD_W-1:0]         s2_h1_reg;
    logic signed [FIELD_W:0]           s2_a_reg;
    logic signed [FIELD_W+1:0]         s2_b_reg;

    logic [FIELD_W-1:0]                s3_near_reg, s3_far_reg;
    logic [FIELD_W-1:0]                s3_h0_reg, s3_h1_reg, s3_h2_reg, s3_h5_reg;
    logic signed [COEF_W+FIELD_W:0]    s3_p0_reg;   // c0 * a
    logic signed [COEF_W+FIELD_W+1:0]  s3_p1_reg;   // c1 * b
    logic signed [COEF_W+FIELD_W-1:0]  s3_p2_reg;   // c2 * h10
    logic [FIELD_W-1:0]                s3_nb;       // rounded, saturated boundary value

    logic [FIELD_W-1:0]                out_data_reg;

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_inr_reg  <= in_inr;
            s1_addr_reg <= in_addr;
            s1_near_reg <= in_near;
            s1_far_reg  <= in_far;
        end
        if (en2)
        begin
            s2_inr_reg  <= s1_inr_reg;
            s2_addr_reg <= s1_addr_reg;
            s2_near_reg <= s1_near_reg;
            s2_far_reg  <= s1_far_reg;
            s2_h0_reg   <= s1_hist[0];
            s2_h1_reg   <= s1_hist[1];
            s2_h2_reg   <= s1_hist[2];
            s2_h5_reg   <= s1_hist[5];
            s2_a_reg    <= s1_a;
            s2_b_reg    <= s1_b;
        end
        if (en3)
        begin
            s3_inr_reg  <= s2_inr_reg;
            s3_addr_reg <= s2_addr_reg;
            s3_near_reg <= s2_near_reg;
            s3_far_reg  <= s2_far_reg;
            s3_h0_reg   <= s2_h0_reg;
            s3_h1_reg   <= s2_h1_reg;
            s3_h2_reg   <= s2_h2_reg;
            s3_h5_reg   <= s2_h5_reg;
            s3_p0_reg   <= coef_zero_reg * s2_a_reg;
            s3_p1_reg   <= coef_one_reg * s2_b_reg;
            s3_p2_reg   <= coef_two_reg * s2_h1_reg;
        end
        if (en_out)
        begin
            out_data_reg <= s3_nb;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: exact sum (32 fraction bits), round half up, saturate
    // ------------------------------------------------------------------
    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) <<< (FRAC_W - 1);

    logic signed [ACC_W-1:0]         s3_p0_ext, s3_p1_ext, s3_p2_ext, s3_h21_al;
    logic signed [ACC_W-1:0]         s3_acc;
    logic [ACC_W-FRAC_W-1:0]         s3_rnd;
    logic                            s3_fits;

    assign s3_p0_ext = {{(ACC_W-COEF_W-FIELD_W-1){s3_p0_reg[COEF_W+FIELD_W]}}, s3_p0_reg};
    assign s3_p1_ext = {{(ACC_W-COEF_W-FIELD_W-2){s3_p1_reg[COEF_W+FIELD_W+1]}}, s3_p1_reg};
    assign s3_p2_ext = {{(ACC_W-COEF_W-FIELD_W){s3_p2_reg[COEF_W+FIELD_W-1]}}, s3_p2_reg};
    // h21 in Q16.16 aligned to 32 fraction bits
    assign s3_h21_al = {{(ACC_W-FIELD_W-FRAC_W){s3_h5_reg[FIELD_W-1]}}, s3_h5_reg,
                        {FRAC_W{1'b0}}};

    assign s3_acc  = s3_p0_ext + s3_p1_ext + s3_p2_ext - s3_h21_al + ROUND_HALF;
    assign s3_rnd  = s3_acc[ACC_W-1:FRAC_W];
    // in range when every bit above the field's sign agrees with it
    assign s3_fits = (s3_rnd[ACC_W-FRAC_W-1:FIELD_W-1] == '0) ||
                     (s3_rnd[ACC_W-FRAC_W-1:FIELD_W-1] == '1);

    always_comb
    begin
        priority if (s3_fits)
        begin
            s3_nb = s3_rnd[FIELD_W-1:0];
        end
        else if (s3_rnd[ACC_W-FRAC_W-1])
        begin
            s3_nb = FIELD_MIN;
        end
        else
        begin
            s3_nb = FIELD_MAX;
        end
    end

    // shifted history: new value and the inner fields become the latest step
    always_comb
    begin
        new_row    = '0;
        new_row[0] = s3_nb;
        new_row[1] = s3_near_reg;
        new_row[2] = s3_far_reg;
        new_row[3] = s3_h0_reg;
        new_row[4] = s3_h1_reg;
        new_row[5] = s3_h2_reg;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy_reg |-> !s_axis_tready)
        else $error("input taken during history sweep");

    a_no_item_write_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy_reg |-> !wr_item)
        else $error("history write collides with sweep");

    a_interlock_s1_s2: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s2_valid_reg && s1_inr_reg && s2_inr_reg)
            |-> (s1_addr_reg != s2_addr_reg))
        else $error("same node in stage 1 and stage 2");

    a_interlock_s1_s3: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s3_valid_reg && s1_inr_reg && s3_inr_reg)
            |-> (s1_addr_reg != s3_addr_reg))
        else $error("same node in stage 1 and stage 3");

    a_result_from_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(s3_valid_reg))
        else $error("result without a word in stage 3");

endmodule

`default_nettype wire

FILE: test/sob_checker.sv
// Checker: predicts absorbing-boundary results from the input stream and compares them.
module sob_checker #(
    parameter int COLS = sob_pkg::COLS_DEF,
    parameter int ROWS = sob_pkg::ROWS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [sob_pkg::REG_IDX_W-1:0]      cfg_addr,
    input  logic [sob_pkg::COEF_W-1:0]         cfg_wdata,
    input  logic                               s_axis_tvalid,
    input  logic                               s_axis_tready,
    input  logic [sob_pkg::TDATA_IN_W-1:0]     s_axis_tdata,
    input  logic [sob_pkg::KIND_W-1:0]         s_axis_tuser,
    input  logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    input  logic [sob_pkg::TDATA_OUT_W-1:0]    m_axis_tdata,
    output int                                 fail_count,
    output int                                 pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import sob_pkg::*;

    localparam int NODES_MAX = ((COLS > ROWS) ? COLS : ROWS) - 1;

    // per side, per node: [0..2] latest step, [3..5] step before
    logic signed [FIELD_W-1:0] node_hist [4][NODES_MAX][HIST_N];
    logic signed [COEF_W-1:0]  c_zero;
    logic signed [COEF_W-1:0]  c_one;
    logic signed [COEF_W-1:0]  c_two;
    logic signed [FIELD_W-1:0] boundary_due [$];

    initial fail_count = 0;
    initial pending = 0;

    function automatic int side_nodes(side_t side);
        return (side == SIDE_LEFT || side == SIDE_RIGHT) ? ROWS - 1 : COLS - 1;
    endfunction

    // New boundary value for one node; shifts that node's history.
    function automatic logic signed [FIELD_W-1:0] advance_node(side_t side, int pos,
            logic signed [FIELD_W-1:0] near_val, logic signed [FIELD_W-1:0] far_val);
        logic signed [FIELD_W-1:0] h [HIST_N];
        longint acc;
        longint rounded;
        logic signed [FIELD_W-1:0] nb;
        bit on_side;
        on_side = pos < side_nodes(side);
        for (int i = 0; i < HIST_N; i++)
        begin
            h[i] = '0;
            if (on_side)
                h[i] = node_hist[int'(side)][pos][i];
        end
        acc = longint'(c_zero) * (longint'(far_val) + longint'(h[3]))
            + longint'(c_one) * (longint'(h[0]) + longint'(h[2])
                                 - longint'(near_val) - longint'(h[4]))
            + longint'(c_two) * longint'(h[1])
            - longint'(h[5]) * 65536;
        rounded = (acc + 32768) >>> FRAC_W;   // round half up
        if (rounded > 64'sd2147483647)
            nb = FIELD_MAX;
        else if (rounded < -64'sd2147483648)
            nb = FIELD_MIN;
        else
            nb = rounded[FIELD_W-1:0];
        if (on_side)
        begin
            node_hist[int'(side)][pos][3] = h[0];
            node_hist[int'(side)][pos][4] = h[1];
            node_hist[int'(side)][pos][5] = h[2];
            node_hist[int'(side)][pos][0] = nb;
            node_hist[int'(side)][pos][1] = near_val;
            node_hist[int'(side)][pos][2] = far_val;
        end
        return nb;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic signed [FIELD_W-1:0] want;
        if (!rst_n)
        begin
            c_zero = COEF_ZERO_RST;
            c_one  = COEF_ONE_RST;
            c_two  = COEF_TWO_RST;
            foreach (node_hist[s, n, i])
                node_hist[s][n][i] = '0;
            boundary_due.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_COEF_ZERO: c_zero = cfg_wdata;
                    REG_COEF_ONE:  c_one  = cfg_wdata;
                    REG_COEF_TWO:  c_two  = cfg_wdata;
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (boundary_due.size() == 0)
                begin
                    $error("boundary_value: no word expected, actual %0d",
                           $signed(m_axis_tdata));
                    fail_count++;
                end
                else
                begin
                    want = boundary_due.pop_front();
                    if (m_axis_tdata !== want)
                    begin
                        $error("boundary_value: expected %0d, actual %0d",
                               want, $signed(m_axis_tdata));
                        fail_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                boundary_due.push_back(advance_node(side_t'(s_axis_tuser),
                                                    int'(s_axis_tdata[7:0]),
                                                    s_axis_tdata[39:8],
                                                    s_axis_tdata[71:40]));
        end
        pending = boundary_due.size();
    end

endmodule

FILE: test/tb_second_order_absorbing_boundary.sv
// Testbench top: drives stimulus and coefficient phases, reports the verdict.
module tb_second_order_absorbing_boundary;
    timeunit 1ns;
    timeprecision 1ps;

    import sob_pkg::*;

    // Worst case per word is roughly a long input gap plus a long output stall
    // plus pipe latency and a same-node hold; the reset sweep of the history RAM adds to it.
    localparam int CYCLE_LIMIT = 500000;
    localparam logic [FIELD_W-1:0] ONE_Q16 = 32'h0001_0000;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    cfg_we = 1'b0;
    logic [REG_IDX_W-1:0]    cfg_addr = '0;
    logic [COEF_W-1:0]       cfg_wdata = '0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    // [7:0] position, [39:8] near_value, [71:40] far_value
    logic [TDATA_IN_W-1:0]   s_axis_tdata = '0;
    // [1:0] kind
    logic [KIND_W-1:0]       s_axis_tuser = '0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    // [31:0] boundary_value
    logic [TDATA_OUT_W-1:0]  m_axis_tdata;

    int fail_count;
    int pending;
    int cycles = 0;
    bit gap_free = 1'b0;     // set for stretches of back-to-back words
    side_t last_side = SIDE_LEFT;
    logic [POS_W-1:0] last_pos = '0;

    second_order_absorbing_boundary u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    sob_checker u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    always #10 clk = ~clk;

    // Watchdog: a hang anywhere ends the run as a failure.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Idle length: mostly none or short, now and then long.
    function automatic int idle_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        if (roll < 98)
            return $urandom_range(4, 8);
        return $urandom_range(15, 40);
    endfunction

    // Result side: ready runs (some very long) broken by stalls.
    initial
    begin
        int run;
        int stall;
        @(posedge rst_n);
        forever
        begin
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
                                              : $urandom_range(1, 8);
            repeat (run)
            begin
                @(negedge clk);
                m_axis_tready <= 1'b1;
            end
            stall = idle_len();
            repeat (stall)
            begin
                @(negedge clk);
                m_axis_tready <= 1'b0;
            end
        end
    end

    // One input word; returns right after the accepting edge.
    task automatic send_word(input side_t side, input logic [POS_W-1:0] pos,
                             input logic [FIELD_W-1:0] near_val,
                             input logic [FIELD_W-1:0] far_val);
        int gap;
        gap = gap_free ? 0 : idle_len();
        repeat (gap)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {far_val, near_val, pos};
        s_axis_tuser  <= side;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        last_side = side;
        last_pos  = pos;
    endtask

    // Drain everything in flight, then load a new coefficient set.
    task automatic load_coefs(input logic [COEF_W-1:0] c0, input logic [COEF_W-1:0] c1,
                              input logic [COEF_W-1:0] c2);
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (6) @(negedge clk);   // pipe is four deep
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_COEF_ZERO;
        cfg_wdata <= c0;
        @(negedge clk);
        cfg_addr  <= REG_COEF_ONE;
        cfg_wdata <= c1;
        @(negedge clk);
        cfg_addr  <= REG_COEF_TWO;
        cfg_wdata <= c2;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Mostly modest Q16.16 values, some full-range, some extremes.
    function automatic logic [FIELD_W-1:0] pick_field();
        logic [31:0] r;
        int roll;
        r = $urandom;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return {{12{r[19]}}, r[19:0]};
        if (roll < 80)
            return r;
        case ($urandom_range(0, 4))
            0: return FIELD_MIN;
            1: return FIELD_MAX;
            2: return '0;
            3: return '1;
            default: return ONE_Q16;
        endcase
    endfunction

    // Random words concentrated on a few hot nodes so histories build up;
    // some repeats of the last node to hit the same-node hold in the pipe.
    task automatic random_words(input int count);
        side_t side;
        logic [POS_W-1:0] pos;
        int roll;
        for (int n = 0; n < count; n++)
        begin
            if (n % 40 == 0)
                gap_free = ($urandom_range(0, 3) == 0);
            roll = $urandom_range(0, 99);
            side = side_t'($urandom_range(0, 3));
            if (roll < 15)
            begin
                side = last_side;
                pos  = last_pos;
            end
            else if (roll < 70)
                pos = POS_W'($urandom_range(0, 5));
            else if (roll < 88)
                pos = POS_W'($urandom_range(0, 254));
            else if (roll < 94)
                pos = 8'd254;
            else
                pos = 8'd255;   // past the end of the side: zero history, no write
            send_word(side, pos, pick_field(), pick_field());
        end
        gap_free = 1'b0;
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed words with reset coefficients.
        // Full-scale in, then zero in: history pushes the result to positive saturation.
        send_word(SIDE_LEFT, 8'd0, FIELD_MAX, FIELD_MAX);
        send_word(SIDE_LEFT, 8'd0, '0, '0);
        send_word(SIDE_LEFT, 8'd0, '0, '0);
        // Same on the last bottom node, negative saturation.
        send_word(SIDE_BOTTOM, 8'd254, FIELD_MIN, FIELD_MIN);
        send_word(SIDE_BOTTOM, 8'd254, '0, '0);
        send_word(SIDE_BOTTOM, 8'd254, FIELD_MIN, FIELD_MAX);
        // Past-the-end node, twice, must not keep any history.
        send_word(SIDE_RIGHT, 8'd255, FIELD_MAX, FIELD_MIN);
        send_word(SIDE_RIGHT, 8'd255, FIELD_MIN, FIELD_MAX);
        send_word(SIDE_TOP, 8'd255, '1, ONE_Q16);
        send_word(SIDE_TOP, 8'd254, '1, ONE_Q16);
        send_word(SIDE_RIGHT, 8'd254, 32'h1234_5678, 32'hedcb_a988);
        // Exact half-LSB sums: rounding tie on both signs.
        send_word(SIDE_TOP, 8'd0, 32'h0000_8000, '0);
        send_word(SIDE_TOP, 8'd1, 32'hffff_8000, '0);
        // Alternating bit patterns on data and position.
        send_word(SIDE_BOTTOM, 8'd0, 32'haaaa_aaaa, 32'h5555_5555);
        send_word(SIDE_BOTTOM, 8'd0, 32'h5555_5555, 32'haaaa_aaaa);
        send_word(SIDE_LEFT, 8'd85, 32'h5555_5555, 32'haaaa_aaaa);
        send_word(SIDE_RIGHT, 8'd170, 32'haaaa_aaaa, 32'h5555_5555);
        // Three steps on one node: every history slot is in use.
        send_word(SIDE_LEFT, 8'd1, ONE_Q16, '1);
        send_word(SIDE_LEFT, 8'd1, 32'h0003_0000, 32'hfffe_0000);
        send_word(SIDE_LEFT, 8'd1, 32'hfffb_0000, 32'h0007_0000);
        random_words(200);

        load_coefs(COEF_W'($urandom_range(0, 20'hfffff)),
                   COEF_W'($urandom_range(0, 20'hfffff)),
                   COEF_W'($urandom_range(0, 20'hfffff)));
        random_words(250);

        // Largest and most negative coefficients.
        load_coefs(20'h7ffff, 20'h7ffff, 20'h7ffff);
        random_words(150);
        load_coefs(20'h80000, 20'h80000, 20'h80000);
        random_words(150);

        // Mixed: c0 zero, c1 high, c2 low.
        load_coefs('0, 20'h7ffff, 20'h80000);
        random_words(100);

        load_coefs(COEF_W'($urandom_range(0, 20'hfffff)),
                   COEF_W'($urandom_range(0, 20'hfffff)),
                   COEF_W'($urandom_range(0, 20'hfffff)));
        random_words(200);

        load_coefs(COEF_ZERO_RST, COEF_ONE_RST, COEF_TWO_RST);
        random_words(100);

        // Drain and let the pipe settle before the verdict.
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
